>>> sv/isqrt_pkg.sv
// ----------------------------------------------------------------------------
// isqrt_pkg
// Widths and constants shared by the integer square root pipeline.
// ----------------------------------------------------------------------------
`default_nettype none

package isqrt_pkg;

    // radicand and root widths
    localparam int OPERAND_WIDTH = 64;
    localparam int ROOT_WIDTH    = 32;

    // one root bit per pipeline stage, two radicand bits consumed per stage
    localparam int NUM_DIGITS = (OPERAND_WIDTH + 1) / 2;
    localparam int PAD_W      = 2 * NUM_DIGITS;
    localparam int REM_W      = NUM_DIGITS + 2;

    // largest root that fits the root field, in a 64-bit frame
    localparam logic [63:0] ROOT_MAX = 64'((65'd1 << ROOT_WIDTH) - 65'd1);

    // bus widths, padded to whole bytes
    localparam int S_TDATA_W = 64;
    localparam int M_TDATA_W = 32;

endpackage

`default_nettype wire

>>> sv/integer_square_root_unit.sv
// ----------------------------------------------------------------------------
// integer_square_root_unit
// Floor square root of a radicand, restoring digit-by-digit, one root bit per
// pipeline stage.
// ----------------------------------------------------------------------------
// pipeline: one input register plus one register stage per root bit,
//   NUM_DIGITS stages, between item acceptance and result valid
// throughput: one item per cycle; the whole pipeline holds while the output
//   item waits for tready
// reset: i_rst_n synchronous active low, clears all valid bits and the
//   signed_operand register; data registers are not reset
`default_nettype none

module integer_square_root_unit import isqrt_pkg::*; (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,

    // configuration: signed_operand
    input  wire logic                 i_cfg_wr_en,
    input  wire logic                 i_cfg_wr_data,

    // radicand stream
    input  wire logic                 i_s_axis_tvalid,
    output logic                      o_s_axis_tready,
    input  wire logic [S_TDATA_W-1:0] i_s_axis_tdata,   // [63:0] operand

    // root stream
    output logic                      o_m_axis_tvalid,
    input  wire logic                 i_m_axis_tready,
    output logic [M_TDATA_W-1:0]      o_m_axis_tdata,   // [31:0] root
    output logic                      o_m_axis_tuser    // [0] no_solution
);

    // configuration register
    logic r_signed;

    // pipeline stage registers, index k holds the item after k root bits
    logic                  r_vld  [0:NUM_DIGITS];
    logic                  r_neg  [0:NUM_DIGITS];
    logic [PAD_W-1:0]      r_opnd [0:NUM_DIGITS];
    logic [REM_W-1:0]      r_rem  [0:NUM_DIGITS];
    logic [NUM_DIGITS-1:0] r_root [0:NUM_DIGITS];

    // next values produced by each digit stage
    logic [PAD_W-1:0]      n_opnd [1:NUM_DIGITS];
    logic [REM_W-1:0]      n_rem  [1:NUM_DIGITS];
    logic [NUM_DIGITS-1:0] n_root [1:NUM_DIGITS];

    logic                  advance;
    logic [63:0]           root_ext;
    logic [63:0]           root_sat;

    // global hold when the output item is not taken
    assign advance         = !r_vld[NUM_DIGITS] || i_m_axis_tready;
    assign o_s_axis_tready = advance;

    // configuration write
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_signed <= 1'b0;
        end else if (i_cfg_wr_en) begin
            r_signed <= i_cfg_wr_data;
        end
    end

    // one trial per stage: bring down two radicand bits, try root bit one
    always_comb begin
        logic [REM_W-1:0] rem_sh;
        logic [REM_W-1:0] trial;
        for (int k = 0; k < NUM_DIGITS; k++) begin
            rem_sh = {r_rem[k][REM_W-3:0], r_opnd[k][PAD_W-1 -: 2]};
            trial  = {r_root[k], 2'b01};
            n_opnd[k+1] = {r_opnd[k][PAD_W-3:0], 2'b00};
            if (rem_sh >= trial) begin
                n_rem[k+1]  = rem_sh - trial;
                n_root[k+1] = {r_root[k][NUM_DIGITS-2:0], 1'b1};
            end else begin
                n_rem[k+1]  = rem_sh;
                n_root[k+1] = {r_root[k][NUM_DIGITS-2:0], 1'b0};
            end
        end
    end

    // valid bits travel with the data
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k <= NUM_DIGITS; k++) begin
                r_vld[k] <= 1'b0;
            end
        end else if (advance) begin
            r_vld[0] <= i_s_axis_tvalid;
            for (int k = 1; k <= NUM_DIGITS; k++) begin
                r_vld[k] <= r_vld[k-1];
            end
        end
    end

    // data path registers
    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_opnd[0] <= PAD_W'(i_s_axis_tdata[OPERAND_WIDTH-1:0]);
            r_neg[0]  <= r_signed && i_s_axis_tdata[OPERAND_WIDTH-1];
            r_rem[0]  <= '0;
            r_root[0] <= '0;
            for (int k = 1; k <= NUM_DIGITS; k++) begin
                r_opnd[k] <= n_opnd[k];
                r_rem[k]  <= n_rem[k];
                r_root[k] <= n_root[k];
                r_neg[k]  <= r_neg[k-1];
            end
        end
    end

    // clamp to the root field and force zero on no solution
    assign root_ext = 64'(r_root[NUM_DIGITS]);
    assign root_sat = (root_ext > ROOT_MAX) ? ROOT_MAX : root_ext;

    assign o_m_axis_tvalid = r_vld[NUM_DIGITS];
    assign o_m_axis_tdata  = r_neg[NUM_DIGITS] ? '0 : root_sat[M_TDATA_W-1:0];
    assign o_m_axis_tuser  = r_neg[NUM_DIGITS];

    // no-solution items carry a zero root
    a_nosol_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && o_m_axis_tuser) |-> (o_m_axis_tdata == '0))
        else $error("no-solution item with nonzero root");

    // input only blocked by output back pressure
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_s_axis_tready |-> (o_m_axis_tvalid && !i_m_axis_tready))
        else $error("input stalled without output back pressure");

    // an accepted item enters the first stage with its sign flag
    a_accept_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_s_axis_tvalid && o_s_axis_tready)
            |=> (r_vld[0] && (r_neg[0] ==
                ($past(r_signed) && $past(i_s_axis_tdata[OPERAND_WIDTH-1])))))
        else $error("accepted item not loaded into first stage");

    // a valid first stage moves one step on advance
    a_stage_move: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_vld[0] && advance) |=> r_vld[1])
        else $error("item lost between stages");

endmodule

`default_nettype wire
